@@ src/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define CHK_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition never holds at any clock edge out of reset.
`define CHK_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ src/itoa_pkg.sv @@
// Types, constants and control program of the integer to ASCII formatter.
`default_nettype none
package itoa_pkg;

  localparam logic [1:0] CMD_UDEC = 2'd0;
  localparam logic [1:0] CMD_SDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;

  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_HEX_BASE = 8'h57;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          DIG_MAX     = 10;
  localparam int          ND_W        = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [5:0]  width;
    logic        zero_fill;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_MUL,
    OP_DIG,
    OP_PADC,
    OP_PAD,
    OP_SIGN,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IDLE,
    COND_DIG_MORE,
    COND_PAD_MORE,
    COND_OUT_MORE
  } cond_e;

  localparam int STEP_W   = 3;
  localparam int PROG_LEN = 7;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PAD  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_OUT  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam ucode_t UCODE [PROG_LEN] = '{
    '{op: OP_WAIT, cond: COND_IDLE,     target: STEP_IDLE},
    '{op: OP_MUL,  cond: COND_NEVER,    target: STEP_IDLE},
    '{op: OP_DIG,  cond: COND_DIG_MORE, target: STEP_MUL},
    '{op: OP_PADC, cond: COND_NEVER,    target: STEP_IDLE},
    '{op: OP_PAD,  cond: COND_PAD_MORE, target: STEP_PAD},
    '{op: OP_SIGN, cond: COND_NEVER,    target: STEP_IDLE},
    '{op: OP_OUT,  cond: COND_OUT_MORE, target: STEP_OUT}
  };

  typedef struct packed {
    logic start;
    logic dig_more;
    logic pad_more;
    logic out_more;
  } stat_t;

  typedef struct packed {
    op_e  op;
    logic busy;
  } ctl_t;

endpackage
`default_nettype wire

@@ src/itoa_seq.sv @@
// Step counter and control program sequencer of the formatter.
`default_nettype none
module itoa_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire itoa_pkg::stat_t       stat_i,
  output itoa_pkg::ctl_t             ctl_o
);

  logic [itoa_pkg::STEP_W-1:0] step_q, step_d;
  itoa_pkg::ucode_t            uc;
  logic                        jump;

  always_comb begin
    uc = itoa_pkg::UCODE[step_q];
    unique case (uc.cond)
      itoa_pkg::COND_NEVER:    jump = 1'b0;
      itoa_pkg::COND_IDLE:     jump = !stat_i.start;
      itoa_pkg::COND_DIG_MORE: jump = stat_i.dig_more;
      itoa_pkg::COND_PAD_MORE: jump = stat_i.pad_more;
      itoa_pkg::COND_OUT_MORE: jump = stat_i.out_more;
      default:                 jump = 1'b0;
    endcase
    if (jump) begin
      step_d = uc.target;
    end else if (step_q == itoa_pkg::STEP_LAST) begin
      step_d = itoa_pkg::STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
    ctl_o.op   = uc.op;
    ctl_o.busy = (step_q != itoa_pkg::STEP_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= itoa_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// Top level: printf-style integer field formatter, one character per word.
//
//   port group          dir  handshake          payload
//   start/busy, req_i   in   start & !busy      itoa_pkg::req_t
//   res_valid_o, res_o  out  res_valid_o        itoa_pkg::res_t
//
// An accepted value runs a seven-step control program: per digit a reciprocal
// multiply, then a digit split; a step to size the fill; a pad step for each
// fill character, run at least once; a sign step; an output step per digit.
// Reset is asynchronous and clears the step counter only.
// Each result word is shown for one cycle; the receiver cannot stall.
`default_nettype none
module integer_to_ascii_formatter #(
  parameter int MAX_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire itoa_pkg::req_t req_i,
  output logic                res_valid_o,
  output itoa_pkg::res_t      res_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int ND = itoa_pkg::ND_W;

  itoa_pkg::ctl_t  ctl;
  itoa_pkg::stat_t stat;

  logic                 neg_q, hex_q;
  logic [7:0]           fill_q;
  logic [WW-1:0]        wid_q, pad_q;
  logic [31:0]          mag_q, quot, rem_full;
  logic [63:0]          prod_q;
  logic [3:0]           dig_q [itoa_pkg::DIG_MAX];
  logic [ND-1:0]        nd_q, nd_prev, len;
  logic [3:0]           rem, cur_dig;
  logic                 accept;

  itoa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  assign busy   = ctl.busy;
  assign accept = start && !ctl.busy;

  always_comb begin
    if (hex_q) begin
      quot = {4'b0, mag_q[31:4]};
      rem  = mag_q[3:0];
    end else begin
      quot = 32'(prod_q[63:itoa_pkg::RECIP_SHIFT]);
      rem  = 4'(mag_q - (quot << 3) - (quot << 1));
    end
    rem_full = 32'(rem);
    nd_prev  = nd_q - 1'b1;
    len      = nd_q + ND'(neg_q);
    cur_dig  = dig_q[nd_prev];
  end

  assign stat.start    = start;
  assign stat.dig_more = (quot != 32'd0);
  assign stat.pad_more = (pad_q > WW'(1));
  assign stat.out_more = (nd_q > ND'(1));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hex_q  <= (req_i.cmd != itoa_pkg::CMD_UDEC) && (req_i.cmd != itoa_pkg::CMD_SDEC);
      neg_q  <= (req_i.cmd == itoa_pkg::CMD_SDEC) && req_i.value[31];
      mag_q  <= ((req_i.cmd == itoa_pkg::CMD_SDEC) && req_i.value[31])
                ? (32'd0 - req_i.value) : req_i.value;
      fill_q <= req_i.zero_fill ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_SPACE;
      wid_q  <= (32'(req_i.width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(req_i.width);
      nd_q   <= '0;
    end else begin
      unique case (ctl.op)
        itoa_pkg::OP_MUL: begin
          prod_q <= 64'(mag_q) * 64'(itoa_pkg::RECIP_10);
        end
        itoa_pkg::OP_DIG: begin
          dig_q[nd_q] <= rem_full[3:0];
          nd_q        <= nd_q + 1'b1;
          mag_q       <= quot;
        end
        itoa_pkg::OP_PADC: begin
          pad_q <= (wid_q > WW'(len)) ? (wid_q - WW'(len)) : '0;
        end
        itoa_pkg::OP_PAD: begin
          if (pad_q != '0) begin
            pad_q <= pad_q - 1'b1;
          end
        end
        itoa_pkg::OP_OUT: begin
          nd_q <= nd_prev;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o    = 1'b0;
    res_o.out_char = fill_q;
    res_o.last     = 1'b0;
    unique case (ctl.op)
      itoa_pkg::OP_PAD: begin
        res_valid_o = (pad_q != '0);
      end
      itoa_pkg::OP_SIGN: begin
        res_valid_o    = neg_q;
        res_o.out_char = itoa_pkg::CHAR_MINUS;
      end
      itoa_pkg::OP_OUT: begin
        res_valid_o    = 1'b1;
        res_o.out_char = (cur_dig < 4'd10) ? (itoa_pkg::CHAR_ZERO + 8'(cur_dig))
                                           : (itoa_pkg::CHAR_HEX_BASE + 8'(cur_dig));
        res_o.last     = (nd_q == ND'(1));
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/itoa_chk.sv @@
// Port-level checker for the formatter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module itoa_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           res_valid_o,
  input wire itoa_pkg::res_t res_o
);

  `CHK_NEVER(a_word_when_idle, res_valid_o && !busy)
  `CHK_ASSERT(a_start_takes_word, start && !busy |=> busy)
  `CHK_ASSERT(a_last_ends_busy, res_valid_o && res_o.last |=> !busy)
  `CHK_ASSERT(a_busy_ends_on_last, $fell(busy) |-> $past(res_valid_o && res_o.last))
  `CHK_ASSERT(a_no_word_at_begin, $rose(busy) |-> !res_valid_o ##1 !res_valid_o)

endmodule

bind integer_to_ascii_formatter itoa_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire
